/* design/lpcsf_pkg.sv */
// Shared types and constants for the order-10 LPC synthesis filter.
// No dependencies; imported by lpcsf_datapath and lpc_synthesis_filter.
`timescale 1ns / 1ps
`default_nettype none

package lpcsf_pkg;

    localparam int ORDER      = 10;
    localparam int HIST_DEPTH = 10;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = PROD_W + 4;
    localparam int PRE_SHIFT  = 4;
    localparam int OUT_W      = 32;
    localparam int CFG_W      = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int TOP_W      = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_LOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_MID   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_UPPER = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOP   = 2'd3;

    localparam logic [CFG_W-1:0] COEF_LOW_RST = 48'd4096;

    localparam logic [OUT_W-1:0]    SAT_MAX  = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0]    SAT_MIN  = 32'h8000_0000;
    localparam logic [OUT_W:0]      RND_BIAS = 33'h0_0000_8000;
    localparam logic [SAMPLE_W-1:0] Y_MAX    = 16'h7FFF;

    typedef logic [ORDER:0][COEF_W-1:0]        t_coefs;
    typedef logic [HIST_DEPTH-1:0][SAMPLE_W-1:0] t_hist;

endpackage

`default_nettype wire

/* design/lpcsf_datapath.sv */
// Filter arithmetic: eleven products, adder tree, shift, saturate and round.
// Purely combinational; depends on lpcsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpcsf_datapath
    import lpcsf_pkg::*;
(
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire t_coefs              i_coefs,
    input  wire t_hist               i_hist,
    output logic [SAMPLE_W-1:0]      o_y
);

    logic signed [PROD_W-1:0] prod [0:ORDER];
    logic signed [ACC_W-1:0]  ext  [0:ORDER];
    logic signed [ACC_W-1:0]  fb_a;
    logic signed [ACC_W-1:0]  fb_b;
    logic signed [ACC_W-1:0]  fb_c;
    logic signed [ACC_W-1:0]  acc;
    logic                     pos_ovf;
    logic                     neg_ovf;
    logic [OUT_W-1:0]         sat;
    logic [OUT_W:0]           rnd;

    always_comb begin
        prod[0] = $signed(i_coefs[0]) * $signed(i_sample);
        for (int k = 1; k <= ORDER; k++) begin
            prod[k] = $signed(i_coefs[k]) * $signed(i_hist[k-1]);
        end
        for (int k = 0; k <= ORDER; k++) begin
            ext[k] = {{(ACC_W-PROD_W){prod[k][PROD_W-1]}}, prod[k]};
        end
    end

    assign fb_a = ext[1] + ext[2] + ext[3] + ext[4];
    assign fb_b = ext[5] + ext[6] + ext[7] + ext[8];
    assign fb_c = ext[9] + ext[10];
    assign acc  = ext[0] - (fb_a + fb_b + fb_c);

    assign pos_ovf = !acc[ACC_W-1] && (acc[ACC_W-2:OUT_W-1-PRE_SHIFT] != '0);
    assign neg_ovf = acc[ACC_W-1] && (acc[ACC_W-2:OUT_W-1-PRE_SHIFT] != '1);

    always_comb begin
        if (pos_ovf) begin
            sat = SAT_MAX;
        end else if (neg_ovf) begin
            sat = SAT_MIN;
        end else begin
            sat = {acc[OUT_W-1-PRE_SHIFT:0], {PRE_SHIFT{1'b0}}};
        end
    end

    // Rounding can only overflow toward the positive limit.
    assign rnd = {sat[OUT_W-1], sat} + RND_BIAS;
    assign o_y = (!rnd[OUT_W] && rnd[OUT_W-1]) ? Y_MAX : rnd[OUT_W-1:OUT_W-SAMPLE_W];

endmodule

`default_nettype wire

/* design/lpc_synthesis_filter.sv */
// Top level of the order-10 LPC synthesis filter with history commit/restore.
// Depends on lpcsf_pkg and lpcsf_datapath.
//
//  Channel   Direction  Payload
//  s         in         tdata[15:0] sample, tlast block_end, tuser commit
//  m         out        tdata[15:0] filtered
//  cfg       in         we, idx[1:0], data[47:0] coefficient words
//
// An accepted beat waits in the input register, where the full filter sum
// is formed, and moves into the output register once the output can take it.
// A new beat can be taken every cycle while the output does not stall; the
// output feeds back into the history at the same edge, so the MAC tree sets the rate.
// Synchronous reset clears the pipeline and both histories and loads the
// default coefficients (a0 = 1.0, all others zero).
// A stalled output holds the input stage, which then drops its tready.
`timescale 1ns / 1ps
`default_nettype none

module lpc_synthesis_filter
    import lpcsf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [SAMPLE_W-1:0]  i_s_tdata,   // [15:0] sample
    input  wire logic                 i_s_tlast,
    input  wire logic                 i_s_tuser,   // [0] commit
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [SAMPLE_W-1:0]       o_m_tdata,   // [15:0] filtered
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0]    r_coef_low;
    logic [CFG_W-1:0]    r_coef_mid;
    logic [CFG_W-1:0]    r_coef_upper;
    logic [TOP_W-1:0]    r_coef_top;
    logic                r_s1_valid;
    logic [SAMPLE_W-1:0] r_s1_sample;
    logic                r_s1_blk;
    logic                r_s1_commit;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_data;
    t_hist               r_work;
    t_hist               r_saved;
    t_hist               n_shifted;
    t_coefs              coefs;
    logic [SAMPLE_W-1:0] y;
    logic                advance;
    logic                take_in;

    assign coefs   = {r_coef_top, r_coef_upper, r_coef_mid, r_coef_low};
    assign advance = r_s1_valid && (!r_out_valid || i_m_tready);
    assign take_in = i_s_tvalid && o_s_tready;

    assign o_s_tready = !r_s1_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign n_shifted = {r_work[HIST_DEPTH-2:0], y};

    lpcsf_datapath u_datapath (
        .i_sample (r_s1_sample),
        .i_coefs  (coefs),
        .i_hist   (r_work),
        .o_y      (y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_low   <= COEF_LOW_RST;
            r_coef_mid   <= '0;
            r_coef_upper <= '0;
            r_coef_top   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COEF_LOW:   r_coef_low   <= i_cfg_data;
                CFG_COEF_MID:   r_coef_mid   <= i_cfg_data;
                CFG_COEF_UPPER: r_coef_upper <= i_cfg_data;
                CFG_COEF_TOP:   r_coef_top   <= i_cfg_data[TOP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_s1_sample <= i_s_tdata;
            r_s1_blk    <= i_s_tlast;
            r_s1_commit <= i_s_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work  <= '0;
            r_saved <= '0;
        end else if (advance) begin
            if (r_s1_blk && !r_s1_commit) begin
                r_work <= r_saved;
            end else begin
                r_work <= n_shifted;
            end
            if (r_s1_blk && r_s1_commit) begin
                r_saved <= n_shifted;
            end
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !r_s1_valid)
        else $error("pipeline not empty after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && o_m_tvalid && !i_m_tready |=> r_s1_valid && o_m_tvalid)
        else $error("input stage lost a beat while output stalled");

    a_restore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_s1_blk && !r_s1_commit |=> r_work == r_saved)
        else $error("history not restored at block end");

    a_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_s1_blk && r_s1_commit |=> r_work == r_saved && r_work[0] == r_out_data)
        else $error("history not committed at block end");

    a_feedback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !(r_s1_blk && !r_s1_commit) |=> r_work[0] == r_out_data)
        else $error("output did not enter the history");

endmodule

`default_nettype wire
